// File: rtl/point_to_hex_cell_core_macros.svh
// Assertion macros used by the checker file
`ifndef POINT_TO_HEX_CELL_CORE_MACROS_SVH
`define POINT_TO_HEX_CELL_CORE_MACROS_SVH

// Same-cycle implication, ignored while reset is held
`define P2H_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, ignored while reset is held
`define P2H_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked in and out of reset
`define P2H_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/p2h_pkg.sv
`timescale 1ns / 1ps

package p2h_pkg;

    localparam int COORD_BITS_DEF      = 32;
    localparam int RECIP_FRAC_BITS_DEF = 32;
    localparam int INV_BITS            = 32;
    localparam int CFG_ADDR_BITS       = 3;

    localparam logic [INV_BITS-1:0] INV_RESET = 32'd65536;

    // register index, taken from paddr[2]
    localparam logic REG_INV_COL = 1'b0;
    localparam logic REG_INV_ROW = 1'b1;

    typedef struct packed {
        logic valid;
        logic origin;
    } p2h_ctl_t;

endpackage

// File: rtl/point_to_hex_cell_core.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake        Beat contents
// s_axis    in   tvalid/tready    point_x, point_y
// m_axis    out  tvalid/tready    cell_col, cell_row; tuser = was_origin
// apb       in   psel/penable     inv_col_width (0x0), inv_row_height (0x4)
//
// One point per cycle unless m_axis back-pressure stalls the pipeline.
// Three register stages: origin offset, the two reciprocal multipliers, binning.
// A stage advances whenever the one after it is empty or advancing.
// Reset clears the pipeline, the origin and restores both reciprocals.

module point_to_hex_cell_core import p2h_pkg::*; #(
    parameter int COORD_BITS      = COORD_BITS_DEF,
    parameter int RECIP_FRAC_BITS = RECIP_FRAC_BITS_DEF,
    localparam int IN_W  = ((2 * COORD_BITS) + 7) / 8 * 8,
    localparam int OUT_W = ((2 * COORD_BITS + 5) + 7) / 8 * 8
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [IN_W-1:0]          s_axis_tdata,  // point_x, point_y
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [OUT_W-1:0]         m_axis_tdata,  // cell_col, cell_row, zero pad
    output logic                     m_axis_tuser,  // was_origin
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_BITS-1:0] paddr,
    input  logic [INV_BITS-1:0]      pwdata,
    output logic [INV_BITS-1:0]      prdata,
    output logic                     pready
);

    localparam int PW       = COORD_BITS + INV_BITS + 2;
    localparam int COL_BITS = COORD_BITS + 2;
    localparam int ROW_BITS = COORD_BITS + 3;
    localparam int PAD_BITS = OUT_W - COL_BITS - ROW_BITS;

    logic [INV_BITS-1:0]   inv_col_reg;
    logic [INV_BITS-1:0]   inv_row_reg;
    logic                  cfg_wr;
    logic                  reg_sel;

    p2h_ctl_t              ctl_s1;
    p2h_ctl_t              ctl_s2;
    p2h_ctl_t              ctl_s3;
    logic                  adv1;
    logic                  adv2;
    logic                  adv3;
    logic [COORD_BITS:0]   dx;
    logic [COORD_BITS:0]   dy;
    logic [PW-1:0]         cprod;
    logic [PW-1:0]         rprod;
    logic [COL_BITS-1:0]   cell_col;
    logic [ROW_BITS-1:0]   cell_row;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign cfg_wr  = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inv_col_reg <= INV_RESET;
            inv_row_reg <= INV_RESET;
        end else if (cfg_wr) begin
            unique case (reg_sel)
                REG_INV_COL: inv_col_reg <= pwdata;
                REG_INV_ROW: inv_row_reg <= pwdata;
                default:     inv_col_reg <= inv_col_reg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_INV_COL: prdata = inv_col_reg;
            REG_INV_ROW: prdata = inv_row_reg;
            default:     prdata = '0;
        endcase
    end

    assign adv3 = ~ctl_s3.valid | m_axis_tready;
    assign adv2 = ~ctl_s2.valid | adv3;
    assign adv1 = ~ctl_s1.valid | adv2;

    assign s_axis_tready = adv1;

    p2h_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv1),
        .in_valid (s_axis_tvalid),
        .point_x  (s_axis_tdata[COORD_BITS-1:0]),
        .point_y  (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
        .ctl      (ctl_s1),
        .dx       (dx),
        .dy       (dy)
    );

    p2h_mult #(
        .COORD_BITS (COORD_BITS)
    ) u_mult (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv2),
        .ctl_in  (ctl_s1),
        .dx      (dx),
        .dy      (dy),
        .inv_col (inv_col_reg),
        .inv_row (inv_row_reg),
        .ctl     (ctl_s2),
        .cprod   (cprod),
        .rprod   (rprod)
    );

    p2h_bin #(
        .COORD_BITS      (COORD_BITS),
        .RECIP_FRAC_BITS (RECIP_FRAC_BITS)
    ) u_bin (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv3),
        .ctl_in   (ctl_s2),
        .cprod    (cprod),
        .rprod    (rprod),
        .ctl      (ctl_s3),
        .cell_col (cell_col),
        .cell_row (cell_row)
    );

    assign m_axis_tvalid = ctl_s3.valid;
    assign m_axis_tuser  = ctl_s3.origin;
    assign m_axis_tdata  = {{PAD_BITS{1'b0}}, cell_row, cell_col};

endmodule

// File: rtl/p2h_front.sv
`timescale 1ns / 1ps

module p2h_front import p2h_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  adv,
    input  logic                  in_valid,
    input  logic [COORD_BITS-1:0] point_x,
    input  logic [COORD_BITS-1:0] point_y,
    output p2h_ctl_t              ctl,
    output logic [COORD_BITS:0]   dx,
    output logic [COORD_BITS:0]   dy
);

    logic [COORD_BITS-1:0] origin_x_reg;
    logic [COORD_BITS-1:0] origin_y_reg;
    logic                  origin_valid_reg;
    p2h_ctl_t              ctl_reg;
    logic [COORD_BITS:0]   dx_reg;
    logic [COORD_BITS:0]   dy_reg;
    logic [COORD_BITS:0]   dx_next;
    logic [COORD_BITS:0]   dy_next;
    logic                  take;

    assign take    = adv & in_valid;
    assign dx_next = {point_x[COORD_BITS-1], point_x}
                   - {origin_x_reg[COORD_BITS-1], origin_x_reg};
    assign dy_next = {point_y[COORD_BITS-1], point_y}
                   - {origin_y_reg[COORD_BITS-1], origin_y_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_valid_reg <= 1'b0;
            ctl_reg          <= '0;
        end else begin
            if (adv) begin
                ctl_reg.valid  <= in_valid;
                ctl_reg.origin <= ~origin_valid_reg;
            end
            if (take) begin
                origin_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take && !origin_valid_reg) begin
            origin_x_reg <= point_x;
            origin_y_reg <= point_y;
        end
        if (adv) begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
        end
    end

    assign ctl = ctl_reg;
    assign dx  = dx_reg;
    assign dy  = dy_reg;

endmodule

// File: rtl/p2h_mult.sv
`timescale 1ns / 1ps

module p2h_mult import p2h_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         adv,
    input  p2h_ctl_t                     ctl_in,
    input  logic [COORD_BITS:0]          dx,
    input  logic [COORD_BITS:0]          dy,
    input  logic [INV_BITS-1:0]          inv_col,
    input  logic [INV_BITS-1:0]          inv_row,
    output p2h_ctl_t                     ctl,
    output logic [COORD_BITS+INV_BITS+1:0] cprod,
    output logic [COORD_BITS+INV_BITS+1:0] rprod
);

    localparam int PW = COORD_BITS + INV_BITS + 2;

    p2h_ctl_t              ctl_reg;
    logic signed [PW-1:0]  cprod_reg;
    logic signed [PW-1:0]  rprod_reg;
    logic signed [PW-1:0]  cprod_next;
    logic signed [PW-1:0]  rprod_next;

    assign cprod_next = PW'($signed(dx)) * PW'($signed({1'b0, inv_col}));
    assign rprod_next = PW'($signed(dy)) * PW'($signed({1'b0, inv_row}));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (adv) begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            cprod_reg <= cprod_next;
            rprod_reg <= rprod_next;
        end
    end

    assign ctl   = ctl_reg;
    assign cprod = cprod_reg;
    assign rprod = rprod_reg;

endmodule

// File: rtl/p2h_bin.sv
`timescale 1ns / 1ps

module p2h_bin import p2h_pkg::*; #(
    parameter int COORD_BITS      = COORD_BITS_DEF,
    parameter int RECIP_FRAC_BITS = RECIP_FRAC_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           adv,
    input  p2h_ctl_t                       ctl_in,
    input  logic [COORD_BITS+INV_BITS+1:0] cprod,
    input  logic [COORD_BITS+INV_BITS+1:0] rprod,
    output p2h_ctl_t                       ctl,
    output logic [COORD_BITS+1:0]          cell_col,
    output logic [COORD_BITS+2:0]          cell_row
);

    localparam int PW       = COORD_BITS + INV_BITS + 2;
    localparam int F        = RECIP_FRAC_BITS;
    localparam int COL_BITS = COORD_BITS + 2;
    localparam int ROW_BITS = COORD_BITS + 3;
    localparam logic [F+1:0] TWO_THIRDS_BOUND = {2'b10, {F{1'b0}}};
    localparam logic [PW:0]  HALF_ROW         = (PW+1)'(1) << (F - 1);

    p2h_ctl_t                    ctl_reg;
    logic [COL_BITS-1:0]         col_reg;
    logic [ROW_BITS-1:0]         row_reg;
    logic [COL_BITS-1:0]         col_next;
    logic [ROW_BITS-1:0]         row_next;

    logic signed [PW-1:0]        cprod_s;
    logic signed [PW-1:0]        rprod_s;
    logic signed [PW:0]          rprod_half;
    logic signed [COL_BITS-1:0]  x_base;
    logic signed [ROW_BITS-1:0]  y_even;
    logic signed [ROW_BITS-1:0]  y_odd;
    logic [ROW_BITS-1:0]         y_base;
    logic                        x_odd;
    logic                        half_odd;
    logic [F+1:0]                fx3;
    logic [F+1:0]                xfrac;
    logic [F+1:0]                yfrac;
    logic                        in_strip;
    logic                        move;
    logic                        y_inc;
    logic                        y_dec;

    assign cprod_s    = $signed(cprod);
    assign rprod_s    = $signed(rprod);
    assign rprod_half = $signed({rprod[PW-1], rprod}) - $signed(HALF_ROW);

    assign x_base = COL_BITS'(cprod_s >>> F);
    assign y_even = ROW_BITS'(rprod_s >>> F);
    assign y_odd  = ROW_BITS'(rprod_half >>> F);
    assign x_odd  = x_base[0];
    assign y_base = x_odd ? y_odd : y_even;

    assign fx3      = {2'b00, cprod[F-1:0]} + {1'b0, cprod[F-1:0], 1'b0};
    assign in_strip = fx3 > TWO_THIRDS_BOUND;
    assign xfrac    = fx3 - TWO_THIRDS_BOUND;
    assign half_odd = rprod[F-1];
    assign yfrac    = {2'b00, rprod[F-2:0], 1'b0};

    always_comb begin
        move  = 1'b0;
        y_inc = 1'b0;
        y_dec = 1'b0;
        if (in_strip) begin
            if (half_odd == x_odd) begin
                if (xfrac > yfrac) begin
                    move  = 1'b1;
                    y_dec = ~x_odd;
                end
            end else begin
                if (yfrac > xfrac) begin
                    move  = 1'b1;
                    y_inc = x_odd;
                end
            end
        end
    end

    always_comb begin
        if (ctl_in.origin) begin
            col_next = '0;
            row_next = '0;
        end else begin
            col_next = x_base + COL_BITS'(move);
            row_next = y_base + ROW_BITS'(y_inc) - ROW_BITS'(y_dec);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (adv) begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign ctl      = ctl_reg;
    assign cell_col = col_reg;
    assign cell_row = row_reg;

endmodule

// File: rtl/p2h_checker.sv
`timescale 1ns / 1ps
`include "point_to_hex_cell_core_macros.svh"

module p2h_checker import p2h_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int OUT_W = ((2 * COORD_BITS + 5) + 7) / 8 * 8
) (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_axis_tready,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata,
    input logic             m_axis_tuser
);

    logic origin_out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_out_reg <= 1'b0;
        end else if (m_axis_tvalid && m_axis_tready && m_axis_tuser) begin
            origin_out_reg <= 1'b1;
        end
    end

    `P2H_ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    `P2H_ASSERT_IMPLY(a_origin_cell_zero, aclk, aresetn, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0)
    `P2H_ASSERT_IMPLY(a_single_origin, aclk, aresetn, origin_out_reg, !(m_axis_tvalid && m_axis_tuser))
    `P2H_ASSERT_NEXT_ALWAYS(a_reset_empty, aclk, !aresetn, !m_axis_tvalid && s_axis_tready)

endmodule

bind point_to_hex_cell_core p2h_checker #(
    .COORD_BITS (COORD_BITS)
) u_p2h_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
